/* rtl/lz77_token_decoder_assert.svh */
// Assertion macros used by the lz77_token_decoder top level
`ifndef LZ77_TOKEN_DECODER_ASSERT_SVH
`define LZ77_TOKEN_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define LZ77TD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lz77 token decoder: check failed");

// Next-cycle implication, sampled on clk_i, off during reset
`define LZ77TD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lz77 token decoder: check failed");

`endif

/* rtl/lz77td_pkg.sv */
// Shared types and constants of the LZ77 token decoder
package lz77td_pkg;

  localparam int OFFSET_W    = 12;
  localparam int LENGTH_W    = 6;
  localparam int BYTE_W      = 8;
  localparam int OFFSET_SPAN = 1 << OFFSET_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
    logic [BYTE_W-1:0]   next_byte;
  } token_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last;
  } out_t;

endpackage

/* rtl/lz77td_token_if.sv */
// Valid/ready channel that carries one token per item
interface lz77td_token_if;
  logic                 valid;
  logic                 ready;
  lz77td_pkg::token_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/lz77td_byte_if.sv */
// Valid/ready channel that carries one decoded byte per item
interface lz77td_byte_if;
  logic               valid;
  logic               ready;
  lz77td_pkg::out_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/lz77td_ram.sv */
// Generic single-write, single-read RAM with registered read data
module lz77td_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/lz77td_front.sv */
// Front end: takes tokens, clamps the length and folds the offset into the ring
module lz77td_front #(
  parameter int HISTORY_DEPTH = 4096,
  parameter int MAX_LENGTH    = 63
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lz77td_token_if.sink   tok_i,
  lz77td_token_if.source tok_o
);
  import lz77td_pkg::*;

  // number of restoring-remainder steps needed to bring any offset below the depth
  function automatic int red_steps(input int d);
    int n;
    n = 0;
    for (int k = 0; k < OFFSET_W; k++) begin
      if ((d << k) < OFFSET_SPAN) n++;
    end
    return n;
  endfunction

  // largest shifted depth that still fits the offset field
  function automatic int top_div(input int d);
    int v;
    v = d;
    for (int k = 1; k < OFFSET_W; k++) begin
      if ((d << k) < OFFSET_SPAN) v = d << k;
    end
    return v;
  endfunction

  localparam int RED_STEPS = red_steps(HISTORY_DEPTH);
  localparam int DIV_TOP   = top_div(HISTORY_DEPTH);
  localparam int SW        = $clog2(RED_STEPS + 2);

  localparam logic [1:0] ST_EMPTY  = 2'd0;
  localparam logic [1:0] ST_REDUCE = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  logic [1:0]          state_q, state_d;
  token_t              tok_q, tok_d;
  logic [OFFSET_W-1:0] div_q, div_d;
  logic [SW-1:0]       step_q, step_d;
  logic                take;

  assign tok_i.ready = (state_q == ST_EMPTY) || ((state_q == ST_FULL) && tok_o.ready);
  assign take        = tok_i.valid && tok_i.ready;

  assign tok_o.valid   = (state_q == ST_FULL);
  assign tok_o.payload = tok_q;

  always_comb begin
    state_d = state_q;
    tok_d   = tok_q;
    div_d   = div_q;
    step_d  = step_q;
    unique case (state_q) inside
      ST_EMPTY, ST_FULL: begin
        if (take) begin
          tok_d.offset    = tok_i.payload.offset;
          tok_d.next_byte = tok_i.payload.next_byte;
          tok_d.length    = (tok_i.payload.length > LENGTH_W'(MAX_LENGTH)) ?
                            LENGTH_W'(MAX_LENGTH) : tok_i.payload.length;
          div_d           = OFFSET_W'(DIV_TOP);
          step_d          = SW'(RED_STEPS);
          state_d         = (RED_STEPS == 0) ? ST_FULL : ST_REDUCE;
        end else if (state_q == ST_FULL && tok_o.ready) begin
          state_d = ST_EMPTY;
        end
      end
      ST_REDUCE: begin
        // one trial subtraction of a shifted depth per cycle
        if (tok_q.offset >= div_q) begin
          tok_d.offset = tok_q.offset - div_q;
        end
        div_d  = div_q >> 1;
        step_d = step_q - SW'(1);
        if (step_q == SW'(1)) begin
          state_d = ST_FULL;
        end
      end
      default: begin
        state_d = ST_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    div_q <= div_d;
  end

endmodule

/* rtl/lz77td_fifo.sv */
// Short token queue between the front end and the copy engine
module lz77td_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  lz77td_token_if.sink   tok_i,
  lz77td_token_if.source tok_o
);
  import lz77td_pkg::*;

  token_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;

  assign tok_i.ready   = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign tok_o.valid   = (cnt_q != '0);
  assign tok_o.payload = mem_q[rd_q];

  assign push = tok_i.valid && tok_i.ready;
  assign pop  = tok_o.valid && tok_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= tok_i.payload;
    end
  end

endmodule

/* rtl/lz77td_back.sv */
// Copy engine: emits copied bytes and the literal, one per cycle unless byte_o stalls, into the history ring
module lz77td_back #(
  parameter int HISTORY_DEPTH = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lz77td_token_if.sink  tok_i,
  lz77td_byte_if.source byte_o
);
  import lz77td_pkg::*;

  localparam int          AW      = $clog2(HISTORY_DEPTH);
  localparam logic [AW:0] DEPTH_W = (AW+1)'(HISTORY_DEPTH);

  // current token
  logic                tok_valid_q;
  logic [OFFSET_W-1:0] off_q;
  logic [LENGTH_W-1:0] cnt_q;
  logic [BYTE_W-1:0]   lit_q;

  // ring position of the next byte to issue, and wrap flag for fill tracking
  logic [AW-1:0] ip_q;
  logic          full_q;

  // read-data stage
  logic              s2_valid_q;
  logic              s2_last_q;
  logic [BYTE_W-1:0] s2_lit_q;
  logic [AW-1:0]     s2_addr_q;
  logic              s2_fwd_q;
  logic              s2_hit_q;
  logic [BYTE_W-1:0] fwd_q;

  // output register
  logic out_valid_q;
  out_t out_q;

  logic              adv, issue, is_copy, take;
  logic [AW:0]       sum, src_w;
  logic [AW-1:0]     src;
  logic              src_hit, src_fwd;
  logic [BYTE_W-1:0] rdata, s2_byte;

  assign adv     = !out_valid_q || byte_o.ready;
  assign issue   = tok_valid_q && adv;
  assign is_copy = (cnt_q != '0);

  assign tok_i.ready = !tok_valid_q || (issue && !is_copy);
  assign take        = tok_i.valid && tok_i.ready;

  assign sum     = {1'b0, ip_q} + DEPTH_W - (AW+1)'(off_q);
  assign src_w   = (sum >= DEPTH_W) ? sum - DEPTH_W : sum;
  assign src     = src_w[AW-1:0];
  // an entry reads as zero until the ring has written it once
  assign src_hit = full_q || (src < ip_q);
  // the byte leaving the read-data stage this cycle is not in the RAM yet
  assign src_fwd = s2_valid_q && (src == s2_addr_q);

  assign s2_byte = s2_last_q ? s2_lit_q :
                   s2_fwd_q  ? fwd_q    :
                   s2_hit_q  ? rdata    : '0;

  lz77td_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (adv && s2_valid_q),
    .waddr_i (s2_addr_q),
    .wdata_i (s2_byte),
    .re_i    (issue && is_copy),
    .raddr_i (src),
    .rdata_o (rdata)
  );

  assign byte_o.valid   = out_valid_q;
  assign byte_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
      cnt_q       <= '0;
      ip_q        <= '0;
      full_q      <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        tok_valid_q <= 1'b1;
        cnt_q       <= tok_i.payload.length;
      end else if (issue && is_copy) begin
        cnt_q <= cnt_q - LENGTH_W'(1);
      end else if (issue) begin
        tok_valid_q <= 1'b0;
      end
      if (issue) begin
        if (ip_q == AW'(HISTORY_DEPTH - 1)) begin
          ip_q   <= '0;
          full_q <= 1'b1;
        end else begin
          ip_q <= ip_q + AW'(1);
        end
      end
      if (adv) begin
        s2_valid_q  <= issue;
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      off_q <= tok_i.payload.offset;
      lit_q <= tok_i.payload.next_byte;
    end
    if (issue) begin
      s2_last_q <= !is_copy;
      s2_lit_q  <= lit_q;
      s2_addr_q <= ip_q;
      s2_fwd_q  <= src_fwd;
      s2_hit_q  <= src_hit;
    end
    if (adv && s2_valid_q) begin
      fwd_q           <= s2_byte;
      out_q.data_byte <= s2_byte;
      out_q.last      <= s2_last_q;
    end
  end

endmodule

/* rtl/lz77_token_decoder.sv */
// LZ77 token decoder top level: front end, token queue and copy engine
//
// token_i takes one token per item: offset, length and next_byte. byte_o gives
// length copied bytes, each taken offset bytes back in the output history, and
// then the literal next_byte with last set. Lengths above MAX_LENGTH are
// clamped, offsets are folded into a ring of HISTORY_DEPTH bytes.
// Both channels move an item on a clock edge with valid and ready high.
// Throughput: one byte per cycle while byte_o is not stalled, set by the
// single read port of the history RAM in the copy engine; overlapping copies
// are served by a forwarding register at the same rate. A token's first byte
// passes the front-end register, the queue, the copy engine's token register,
// its read-data stage and its output register, after the front end's offset
// fold steps when HISTORY_DEPTH is below 4096. A two-entry queue lets the
// front end take further tokens while the copy engine is busy. When byte_o is
// stalled the copy engine holds and the queue fills, then token_i drops ready.
// Reset clears all control state at once; the history is not swept, a fill
// mark makes every entry read as zero until it is first written, so a token
// is accepted in the first cycle after reset.
`include "lz77_token_decoder_assert.svh"

module lz77_token_decoder #(
  parameter int HISTORY_DEPTH = 4096,
  parameter int MAX_LENGTH    = 63
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lz77td_token_if.sink   token_i,
  lz77td_byte_if.source  byte_o
);
  import lz77td_pkg::*;

  localparam logic [2:0] INFLIGHT_MAX = 3'd6;

  lz77td_token_if fe_if ();
  lz77td_token_if bk_if ();

  lz77td_front #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_LENGTH    (MAX_LENGTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (token_i),
    .tok_o  (fe_if)
  );

  lz77td_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (fe_if),
    .tok_o  (bk_if)
  );

  lz77td_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (bk_if),
    .byte_o (byte_o)
  );

  // tokens taken whose closing literal has not yet left
  logic [2:0] inflight_q;
  logic       in_take, last_take;
  logic       fe_clean;

  assign in_take   = token_i.valid && token_i.ready;
  assign last_take = byte_o.valid && byte_o.ready && byte_o.payload.last;

  // a classified token carries a clamped length and an offset inside the ring
  assign fe_clean = (fe_if.payload.length <= LENGTH_W'(MAX_LENGTH)) &&
                    (32'(fe_if.payload.offset) < HISTORY_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 3'(in_take) - 3'(last_take);
    end
  end

  `LZ77TD_ASSERT_IMP(a_fe_clean, fe_if.valid, fe_clean)
  `LZ77TD_ASSERT_IMP(a_last_owned, last_take, inflight_q != '0)
  `LZ77TD_ASSERT_IMP(a_inflight_bound, 1'b1, inflight_q <= INFLIGHT_MAX)
  `LZ77TD_ASSERT_NXT(a_take_counted, in_take, inflight_q != '0)

endmodule
